[design/fgae_pkg.sv]
// shared types, widths, reset values and helpers for the fixed-gain altitude estimator
// no dependencies; used by fgae_ctrl, fgae_dp and fixed_gain_altitude_estimator_top

package fgae_pkg;

    localparam int DataW  = 40;
    localparam int StampW = 48;
    localparam int GainW  = 18;
    localparam int MaxDtW = 17;
    localparam int ErrW   = DataW + 1;
    localparam int MagAW  = ErrW;
    localparam int MagBW  = StampW;
    localparam int ChunkW = MagBW / 2;
    localparam int ProdW  = MagAW + MagBW;
    localparam int SumW   = DataW + 2;
    localparam int CfgIdxW = 3;

    localparam logic [GainW-1:0]  GainPaRst = 18'd6554;
    localparam logic [GainW-1:0]  GainVaRst = 18'd3277;
    localparam logic [GainW-1:0]  GainVcRst = 18'd3277;
    localparam logic [GainW-1:0]  GainAaRst = 18'd65536;
    localparam logic [MaxDtW-1:0] MaxDtRst  = 17'd65536;

    // last multiplier operation of each item kind
    localparam logic [1:0] LastOpPredict = 2'd2;
    localparam logic [1:0] LastOpUpdate  = 2'd3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_PA = 3'd0,
        CFG_GAIN_VA = 3'd1,
        CFG_GAIN_VC = 3'd2,
        CFG_GAIN_AA = 3'd3,
        CFG_MAX_DT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_PREDICT = 2'd0,
        ACT_ALT     = 2'd1,
        ACT_ACC     = 2'd2,
        ACT_BOTH    = 2'd3
    } action_t;

    typedef struct packed {
        logic       capture;
        logic       prep;
        logic       load;
        logic       mul_step;
        logic       chunk_hi;
        logic       round;
        logic       commit;
        logic [1:0] op_idx;
    } cmd_t;

    typedef struct packed {
        logic is_predict;
    } sts_t;

    // saturate a widened sum to the 40-bit signed range
    function automatic logic signed [DataW-1:0] sat_sum(input logic signed [SumW-1:0] x);
        logic signed [SumW-1:0] hi_lim;
        logic signed [SumW-1:0] lo_lim;
        hi_lim = 42'sd549755813887;
        lo_lim = -42'sd549755813888;
        if (x > hi_lim)
        begin
            return hi_lim[DataW-1:0];
        end
        else if (x < lo_lim)
        begin
            return lo_lim[DataW-1:0];
        end
        return x[DataW-1:0];
    endfunction

endpackage

[design/fgae_ctrl.sv]
// sequencer for the estimator: steps each transaction through prep, multiply and commit
// depends on fgae_pkg for command and status types

module fgae_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fgae_pkg::sts_t     sts,
    output fgae_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_LOAD   = 6'b000100,
        S_MUL    = 6'b001000,
        S_ROUND  = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_idx_reg, op_idx_next;
    logic       chunk_reg, chunk_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;
    logic       last_op;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign last_op   = sts.is_predict ? (op_idx_reg == fgae_pkg::LastOpPredict)
                                      : (op_idx_reg == fgae_pkg::LastOpUpdate);
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_idx_next = op_idx_reg;
        chunk_next  = chunk_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                op_idx_next = '0;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                chunk_next = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (chunk_reg)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    chunk_next = 1'b1;
                end
            end
            S_ROUND:
            begin
                if (last_op)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    op_idx_next = op_idx_reg + 2'd1;
                    state_next  = S_LOAD;
                end
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.prep     = (state_reg == S_PREP);
        cmd.load     = (state_reg == S_LOAD);
        cmd.mul_step = (state_reg == S_MUL);
        cmd.chunk_hi = chunk_reg;
        cmd.round    = (state_reg == S_ROUND);
        cmd.commit   = (state_reg == S_COMMIT) && slot_free;
        cmd.op_idx   = op_idx_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_idx_reg    <= '0;
            chunk_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_idx_reg    <= op_idx_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PREP)
        else $error("accepted transaction did not move to prep");

    a_commit_after_last_op: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT |->
            (sts.is_predict && op_idx_reg == fgae_pkg::LastOpPredict) ||
            (!sts.is_predict && op_idx_reg == fgae_pkg::LastOpUpdate))
        else $error("commit reached before all products were formed");

    a_round_after_both_chunks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> $past(state_reg) == S_MUL && $past(chunk_reg))
        else $error("rounding started before the upper chunk was accumulated");

endmodule

[design/fgae_dp.sv]
// datapath of the estimator: config registers, state, dt and error forming,
// a two-chunk sign-magnitude multiplier with rounding, and the output register; uses fgae_pkg

module fgae_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fgae_pkg::cmd_t                       cmd,
    output fgae_pkg::sts_t                       sts,
    input  logic [1:0]                           action,
    input  logic [fgae_pkg::StampW-1:0]          time_stamp,
    input  logic signed [fgae_pkg::DataW-1:0]    meas_altitude,
    input  logic signed [fgae_pkg::DataW-1:0]    meas_acceleration,
    input  logic                                 cfg_we,
    input  logic [fgae_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [fgae_pkg::GainW-1:0]           cfg_data,
    output logic signed [fgae_pkg::DataW-1:0]    est_position,
    output logic signed [fgae_pkg::DataW-1:0]    est_velocity,
    output logic signed [fgae_pkg::DataW-1:0]    est_acceleration
);

    localparam int DW = fgae_pkg::DataW;
    localparam int SW = fgae_pkg::StampW;
    localparam int EW = fgae_pkg::ErrW;
    localparam int AW = fgae_pkg::MagAW;
    localparam int BW = fgae_pkg::MagBW;
    localparam int CW = fgae_pkg::ChunkW;
    localparam int PW = fgae_pkg::ProdW;
    localparam int XW = fgae_pkg::SumW;
    localparam int GW = fgae_pkg::GainW;
    localparam int TW = fgae_pkg::MaxDtW;

    localparam logic [PW-1:0] HalfLsb16 = PW'(1) << (fgae_pkg::GainW - 3);
    localparam logic [PW-1:0] HalfLsb17 = PW'(1) << (fgae_pkg::GainW - 2);
    localparam logic [PW-1:0] PosLimit  = (PW'(1) << (DW - 1)) - PW'(1);
    localparam logic [PW-1:0] NegLimit  = PW'(1) << (DW - 1);

    // configuration
    logic [GW-1:0] gain_pa_reg, gain_va_reg, gain_vc_reg, gain_aa_reg;
    logic [TW-1:0] max_dt_reg;

    // filter state
    logic signed [DW-1:0] pos_reg, vel_reg, acc_reg;
    logic signed [DW-1:0] pos_next, vel_next, acc_next;
    logic [SW-1:0]        last_stamp_reg;

    // captured transaction and derived operands
    logic [1:0]           action_reg;
    logic [SW-1:0]        stamp_in_reg;
    logic signed [DW-1:0] alt_in_reg, acc_in_reg;
    logic signed [SW-1:0] dt_reg, dt_next;
    logic signed [EW-1:0] e_alt_reg, e_acc_reg, e_alt_next, e_acc_next;

    // multiplier
    logic signed [EW-1:0] op_a;
    logic signed [SW:0]   op_b;
    logic                 op_half17;
    logic [AW-1:0]        a_mag_reg, a_mag_next;
    logic [BW-1:0]        b_mag_reg, b_mag_next;
    logic                 neg_reg, half17_reg;
    logic [AW+CW-1:0]     part;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [PW-1:0]        rsum, qmag;
    logic signed [DW-1:0] rounded;
    logic signed [DW-1:0] res_reg [4];

    logic [SW-1:0]        diff;
    logic signed [SW-1:0] max_dt_ext;

    assign sts.is_predict = (action_reg == fgae_pkg::ACT_PREDICT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pa_reg <= fgae_pkg::GainPaRst;
            gain_va_reg <= fgae_pkg::GainVaRst;
            gain_vc_reg <= fgae_pkg::GainVcRst;
            gain_aa_reg <= fgae_pkg::GainAaRst;
            max_dt_reg  <= fgae_pkg::MaxDtRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fgae_pkg::CFG_GAIN_PA: gain_pa_reg <= cfg_data;
                fgae_pkg::CFG_GAIN_VA: gain_va_reg <= cfg_data;
                fgae_pkg::CFG_GAIN_VC: gain_vc_reg <= cfg_data;
                fgae_pkg::CFG_GAIN_AA: gain_aa_reg <= cfg_data;
                fgae_pkg::CFG_MAX_DT:  max_dt_reg  <= cfg_data[TW-1:0];
                default:               ;
            endcase
        end
    end

    // dt is the wrapped signed stamp difference, clamped above only
    assign diff       = stamp_in_reg - last_stamp_reg;
    assign max_dt_ext = $signed({{(SW-TW){1'b0}}, max_dt_reg});

    always_comb
    begin
        dt_next = $signed(diff);
        if ($signed(diff) > max_dt_ext)
        begin
            dt_next = max_dt_ext;
        end
        e_alt_next = '0;
        e_acc_next = '0;
        if (action_reg[0])
        begin
            e_alt_next = EW'(alt_in_reg) - EW'(pos_reg);
        end
        if (action_reg[1])
        begin
            e_acc_next = EW'(acc_in_reg) - EW'(acc_reg);
        end
    end

    // operand pair for each product
    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        op_half17 = 1'b0;
        if (sts.is_predict)
        begin
            op_b = (SW+1)'(dt_reg);
            case (cmd.op_idx)
                2'd0: op_a = EW'(acc_reg);
                2'd1: op_a = EW'(vel_reg);
                2'd2:
                begin
                    op_a      = EW'(res_reg[0]);
                    op_half17 = 1'b1;
                end
                default: op_a = '0;
            endcase
        end
        else
        begin
            case (cmd.op_idx)
                2'd0:
                begin
                    op_a = e_alt_reg;
                    op_b = $signed({{(SW+1-GW){1'b0}}, gain_pa_reg});
                end
                2'd1:
                begin
                    op_a = e_alt_reg;
                    op_b = $signed({{(SW+1-GW){1'b0}}, gain_va_reg});
                end
                2'd2:
                begin
                    op_a = e_acc_reg;
                    op_b = $signed({{(SW+1-GW){1'b0}}, gain_vc_reg});
                end
                2'd3:
                begin
                    op_a = e_acc_reg;
                    op_b = $signed({{(SW+1-GW){1'b0}}, gain_aa_reg});
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    assign a_mag_next = op_a[EW-1] ? AW'(-op_a) : AW'(op_a);
    assign b_mag_next = op_b[SW] ? BW'(-op_b) : BW'(op_b);

    // one 41 x 24 partial product per cycle, low chunk first
    assign part = a_mag_reg * (cmd.chunk_hi ? b_mag_reg[BW-1:CW] : b_mag_reg[CW-1:0]);
    assign prod_next = cmd.chunk_hi ? (prod_reg + {part, {CW{1'b0}}})
                                    : {{(PW-AW-CW){1'b0}}, part};

    // round half away from zero on the magnitude, then saturate
    assign rsum = prod_reg + (half17_reg ? HalfLsb17 : HalfLsb16);
    assign qmag = half17_reg ? (rsum >> (fgae_pkg::GainW - 1))
                             : (rsum >> (fgae_pkg::GainW - 2));

    always_comb
    begin
        if (neg_reg)
        begin
            if (qmag > NegLimit)
            begin
                rounded = $signed(NegLimit[DW-1:0]);
            end
            else
            begin
                rounded = -$signed(qmag[DW-1:0]);
            end
        end
        else
        begin
            if (qmag > PosLimit)
            begin
                rounded = $signed(PosLimit[DW-1:0]);
            end
            else
            begin
                rounded = $signed(qmag[DW-1:0]);
            end
        end
    end

    always_comb
    begin
        if (sts.is_predict)
        begin
            pos_next = fgae_pkg::sat_sum(XW'(pos_reg) + XW'(res_reg[1]) + XW'(res_reg[2]));
            vel_next = fgae_pkg::sat_sum(XW'(vel_reg) + XW'(res_reg[0]));
            acc_next = acc_reg;
        end
        else
        begin
            pos_next = fgae_pkg::sat_sum(XW'(pos_reg) + XW'(res_reg[0]));
            vel_next = fgae_pkg::sat_sum(XW'(vel_reg) + XW'(res_reg[1]) + XW'(res_reg[2]));
            acc_next = fgae_pkg::sat_sum(XW'(acc_reg) + XW'(res_reg[3]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            vel_reg        <= '0;
            acc_reg        <= '0;
            last_stamp_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
            if (sts.is_predict)
            begin
                last_stamp_reg <= stamp_in_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            stamp_in_reg <= time_stamp;
            alt_in_reg   <= meas_altitude;
            acc_in_reg   <= meas_acceleration;
        end
        if (cmd.prep)
        begin
            dt_reg    <= dt_next;
            e_alt_reg <= e_alt_next;
            e_acc_reg <= e_acc_next;
        end
        if (cmd.load)
        begin
            a_mag_reg  <= a_mag_next;
            b_mag_reg  <= b_mag_next;
            neg_reg    <= op_a[EW-1] ^ op_b[SW];
            half17_reg <= op_half17;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.round)
        begin
            res_reg[cmd.op_idx] <= rounded;
        end
        if (cmd.commit)
        begin
            est_position     <= pos_next;
            est_velocity     <= vel_next;
            est_acceleration <= acc_next;
        end
    end

    a_output_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> est_position == pos_reg && est_velocity == vel_reg &&
                       est_acceleration == acc_reg)
        else $error("output register differs from committed state");

    a_dt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep && sts.is_predict |=> dt_reg <= max_dt_ext)
        else $error("time step exceeds its clamp");

endmodule

[design/fixed_gain_altitude_estimator_top.sv]
// top level of the fixed-gain altitude estimator (alpha-beta-gamma filter, Q24.16)
// depends on fgae_pkg, fgae_ctrl and fgae_dp
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  s_*      | s_tvalid/s_tready | tuser action, tdata stamp/altitude/acceleration
//  m_*      | m_tvalid/m_tready | tdata position/velocity/acceleration
//  cfg_*    | cfg_valid/ready   | cfg_index register, cfg_data value
//
// one transaction at a time: each passes the idle state that accepts it, prep, then for every
// product of the shared 41 x 24 multiplier a load, two chunks and a rounding step (three
// products for predict, four for update), then commit; commit holds while the previous
// result is still unread
// the result sits in an output register, so the next transaction is accepted while it waits
// reset clears the estimates and last stamp and loads the default gains; cfg_ready is always high

module fixed_gain_altitude_estimator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [1:0]                          s_tuser,   // [1:0] action
    input  logic [127:0]                        s_tdata,   // [47:0] time_stamp,
                                                           // [87:48] meas_altitude,
                                                           // [127:88] meas_acceleration
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [119:0]                        m_tdata,   // [39:0] est_position,
                                                           // [79:40] est_velocity,
                                                           // [119:80] est_acceleration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fgae_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [fgae_pkg::GainW-1:0]          cfg_data
);

    fgae_pkg::cmd_t                    cmd;
    fgae_pkg::sts_t                    sts;
    logic signed [fgae_pkg::DataW-1:0] est_position;
    logic signed [fgae_pkg::DataW-1:0] est_velocity;
    logic signed [fgae_pkg::DataW-1:0] est_acceleration;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {est_acceleration, est_velocity, est_position};

    fgae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fgae_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .action            (s_tuser),
        .time_stamp        (s_tdata[47:0]),
        .meas_altitude     ($signed(s_tdata[87:48])),
        .meas_acceleration ($signed(s_tdata[127:88])),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .est_position      (est_position),
        .est_velocity      (est_velocity),
        .est_acceleration  (est_acceleration)
    );

endmodule

[verif/fgae_checker.sv]
// scoreboard for the fixed-gain altitude estimator: watches the stream and register channels,
// keeps its own Q24.16 copy of the filter and compares every result field by field
// depends on fgae_pkg

module fgae_checker
    import fgae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [1:0]           s_tuser,
    input  logic [127:0]         s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [119:0]         m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [GainW-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending
);

    localparam logic signed [63:0] PosLimit = 64'sd549755813887;
    localparam logic signed [63:0] NegLimit = -64'sd549755813888;
    localparam int                 FracShift = 16;

    typedef struct packed {
        logic signed [DataW-1:0] pos;
        logic signed [DataW-1:0] vel;
        logic signed [DataW-1:0] acc;
    } estimate_t;

    estimate_t          estimates_due[$];
    logic signed [63:0] pos_est;
    logic signed [63:0] vel_est;
    logic signed [63:0] acc_est;
    logic [StampW-1:0]  prev_stamp;
    logic [GainW-1:0]   k_pa;
    logic [GainW-1:0]   k_va;
    logic [GainW-1:0]   k_vc;
    logic [GainW-1:0]   k_aa;
    logic [MaxDtW-1:0]  dt_cap;

    function automatic logic signed [63:0] clip40(input logic signed [63:0] x);
        if (x > PosLimit)
        begin
            return PosLimit;
        end
        if (x < NegLimit)
        begin
            return NegLimit;
        end
        return x;
    endfunction

    // (x*y) >> sh on magnitudes, round half away from zero, then clip to 40 bits
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] x,
                                                          input logic signed [63:0] y,
                                                          input int sh);
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] q;
        logic         flip;
        flip = (x < 0) != (y < 0);
        mx = (x < 0) ? 128'(-x) : 128'(x);
        my = (y < 0) ? 128'(-y) : 128'(y);
        q = (mx * my + (128'd1 << (sh - 1))) >> sh;
        if (flip)
        begin
            if (q > 128'd549755813888)
            begin
                return NegLimit;
            end
            return -$signed(q[63:0]);
        end
        if (q > 128'd549755813887)
        begin
            return PosLimit;
        end
        return $signed(q[63:0]);
    endfunction

    task automatic advance_filter(input action_t act, input logic [StampW-1:0] stamp,
                                  input logic signed [DataW-1:0] alt,
                                  input logic signed [DataW-1:0] accel);
        logic [StampW-1:0]  diff;
        logic signed [63:0] dt;
        logic signed [63:0] t_acc;
        logic signed [63:0] t_vel;
        logic signed [63:0] t_half;
        logic signed [63:0] e_alt;
        logic signed [63:0] e_acc;
        if (act == ACT_PREDICT)
        begin
            diff = stamp - prev_stamp;
            dt = $signed(diff);
            if (dt > $signed({47'd0, dt_cap}))
            begin
                dt = $signed({47'd0, dt_cap});
            end
            prev_stamp = stamp;
            t_acc = scaled_product(acc_est, dt, FracShift);
            t_vel = scaled_product(vel_est, dt, FracShift);
            // half of a*dt*dt, built from the already clipped a*dt
            t_half = scaled_product(t_acc, dt, FracShift + 1);
            pos_est = clip40(pos_est + t_vel + t_half);
            vel_est = clip40(vel_est + t_acc);
        end
        else
        begin
            e_alt = (act == ACT_ALT || act == ACT_BOTH) ? alt - pos_est : 64'sd0;
            e_acc = (act == ACT_ACC || act == ACT_BOTH) ? accel - acc_est : 64'sd0;
            pos_est = clip40(pos_est + scaled_product($signed({46'd0, k_pa}), e_alt, FracShift));
            vel_est = clip40(vel_est
                             + scaled_product($signed({46'd0, k_va}), e_alt, FracShift)
                             + scaled_product($signed({46'd0, k_vc}), e_acc, FracShift));
            acc_est = clip40(acc_est + scaled_product($signed({46'd0, k_aa}), e_acc, FracShift));
        end
        estimates_due.push_back('{pos: pos_est[DataW-1:0], vel: vel_est[DataW-1:0],
                                  acc: acc_est[DataW-1:0]});
    endtask

    task automatic compare_field(input string name, input logic signed [DataW-1:0] want,
                                 input logic signed [DataW-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [119:0] data);
        estimate_t want;
        if (estimates_due.size() == 0)
        begin
            $error("estimate transaction with nothing outstanding: %h", data);
            mismatches++;
        end
        else
        begin
            want = estimates_due.pop_front();
            compare_field("est_position", want.pos, data[39:0]);
            compare_field("est_velocity", want.vel, data[79:40]);
            compare_field("est_acceleration", want.acc, data[119:80]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimates_due.delete();
            pos_est = '0;
            vel_est = '0;
            acc_est = '0;
            prev_stamp = '0;
            k_pa = GainPaRst;
            k_va = GainVaRst;
            k_vc = GainVcRst;
            k_aa = GainAaRst;
            dt_cap = MaxDtRst;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_PA: k_pa = cfg_data;
                    CFG_GAIN_VA: k_va = cfg_data;
                    CFG_GAIN_VC: k_vc = cfg_data;
                    CFG_GAIN_AA: k_aa = cfg_data;
                    CFG_MAX_DT:  dt_cap = cfg_data[MaxDtW-1:0];
                    default:     ;
                endcase
            end
            // results leave before the item accepted on the same edge is predicted
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                advance_filter(action_t'(s_tuser), s_tdata[47:0], s_tdata[87:48],
                               s_tdata[127:88]);
            end
            pending <= estimates_due.size();
        end
    end

endmodule

[verif/testbench.sv]
// top of the fixed-gain altitude estimator test: clock, reset, stimulus and verdict
// depends on fgae_pkg, fixed_gain_altitude_estimator_top and fgae_checker

module testbench;

    import fgae_pkg::*;

    localparam int                HoldCycles = 400;
    localparam int                StallLimit = 2000;
    localparam int                TailCycles = 40;
    localparam int                PhaseItems = 305;
    localparam int                FirstSpareIdx = CFG_MAX_DT + 1;
    localparam logic [DataW-1:0]  AltTop = 40'h7F_FFFF_FFFF;
    localparam logic [DataW-1:0]  AltBottom = 40'h80_0000_0000;
    localparam logic [GainW-1:0]  GainMax = 18'd131072;
    localparam logic [GainW-1:0]  AllOnes = 18'h3FFFF;
    localparam logic [StampW-1:0] StampOnes = 48'hFFFF_FFFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [1:0]           s_tuser;
    logic [127:0]         s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [119:0]         m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [GainW-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;
    int                   stalled_cycles;
    int                   sent_by_kind[4];
    int                   settings;
    bit                   quiet;
    bit                   hold_req;
    logic [StampW-1:0]    now_stamp;

    fixed_gain_altitude_estimator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fgae_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // valid stays high from one item to the next unless a gap is drawn
    task automatic send_item(input action_t act, input logic [StampW-1:0] stamp,
                             input logic [DataW-1:0] alt, input logic [DataW-1:0] accel);
        if (!quiet && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {accel, alt, stamp};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent_by_kind[act]++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // all five registers plus one write to an unused index, only once the filter is idle
    task automatic program_regs(input logic [GainW-1:0] pa, input logic [GainW-1:0] va,
                                input logic [GainW-1:0] vc, input logic [GainW-1:0] aa,
                                input logic [GainW-1:0] dt_word);
        drain();
        write_reg(CFG_GAIN_PA, pa);
        write_reg(CFG_GAIN_VA, va);
        write_reg(CFG_GAIN_VC, vc);
        write_reg(CFG_GAIN_AA, aa);
        write_reg(CFG_MAX_DT, dt_word);
        write_reg(CfgIdxW'($urandom_range(FirstSpareIdx, 2 ** CfgIdxW - 1)), GainW'($urandom()));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [DataW-1:0] pick_meas();
        int unsigned sel;
        int          near_val;
        logic [63:0] raw;
        sel = $urandom_range(99);
        raw = {$urandom(), $urandom()};
        if (sel < 60)
        begin
            // within about a kilometre of the origin
            near_val = int'($urandom_range(0, 1 << 27)) - (1 << 26);
            return 40'(near_val);
        end
        if (sel < 90)
        begin
            return raw[DataW-1:0];
        end
        case ($urandom_range(3))
            0:       return AltTop;
            1:       return AltBottom;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic random_item;
        action_t          act;
        logic [63:0]      raw;
        int unsigned      sel;
        logic [StampW-1:0] stamp;
        raw = {$urandom(), $urandom()};
        sel = $urandom_range(99);
        act = ($urandom_range(99) < 40) ? ACT_PREDICT : action_t'($urandom_range(1, 3));
        if (act == ACT_PREDICT)
        begin
            // mostly a steady clock, sometimes a jump anywhere or a step back
            if (sel < 80)
            begin
                now_stamp = now_stamp + $urandom_range(0, 70000);
            end
            else if (sel < 90)
            begin
                now_stamp = raw[StampW-1:0];
            end
            else
            begin
                now_stamp = now_stamp - $urandom_range(0, 70000);
            end
            stamp = now_stamp;
        end
        else
        begin
            stamp = raw[StampW-1:0];
        end
        send_item(act, stamp, pick_meas(), pick_meas());
    endtask

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= StallLimit)
        begin
            $display("fixed_gain_altitude_estimator_top test failed");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        now_stamp = '0;
        settings = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: field extremes, backward and wrapping time steps
        send_item(ACT_ALT, StampOnes, AltTop, AltBottom);
        send_item(ACT_ACC, '0, AltBottom, AltTop);
        send_item(ACT_BOTH, StampOnes, AltBottom, AltBottom);
        send_item(ACT_PREDICT, '0, AltTop, AltTop);
        send_item(ACT_PREDICT, 48'd100, '0, '0);
        send_item(ACT_PREDICT, StampOnes, '1, '1);
        send_item(ACT_PREDICT, '0, '0, '0);
        send_item(ACT_PREDICT, 48'h7FFF_FFFF_FFFF, '0, '0);
        send_item(ACT_PREDICT, 48'h8000_0000_0000, '0, '0);
        send_item(ACT_PREDICT, '0, '0, '0);
        send_item(ACT_ALT, StampOnes, '0, AltTop);
        send_item(ACT_BOTH, '0, 40'sd809041920, -40'sd642908);

        // largest gains, clamp word with its unused top bit set
        program_regs(GainMax, GainMax, GainMax, GainMax, AllOnes);
        send_item(ACT_BOTH, '0, AltTop, AltTop);
        send_item(ACT_PREDICT, 48'd200000, '0, '0);
        send_item(ACT_PREDICT, 48'd331071, '0, '0);
        send_item(ACT_ALT, '0, AltBottom, '0);

        // zero gains and a zero clamp: forward steps vanish, backward ones remain
        program_regs('0, '0, '0, '0, '0);
        send_item(ACT_PREDICT, 48'd500000, '0, '0);
        send_item(ACT_PREDICT, 48'd400000, '0, '0);
        send_item(ACT_BOTH, StampOnes, AltTop, AltBottom);
        send_item(ACT_ACC, '0, '0, 40'd1);

        program_regs(GainPaRst, GainVaRst, GainVcRst, GainAaRst, 18'd1);
        send_item(ACT_PREDICT, 48'd400001, '0, '0);
        send_item(ACT_ALT, '0, '1, '0);
        now_stamp = 48'd400001;

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_regs(GainPaRst, GainVaRst, GainVcRst, GainAaRst, MaxDtRst);
                1: program_regs(GainMax, GainMax, GainMax, GainMax, MaxDtRst);
                2: program_regs(GainW'($urandom_range(0, GainMax)),
                                GainW'($urandom_range(0, GainMax)),
                                GainW'($urandom_range(0, GainMax)),
                                GainW'($urandom_range(0, GainMax)),
                                GainW'($urandom_range(1, 65536)));
                3: program_regs(GainW'($urandom()), GainW'($urandom()), GainW'($urandom()),
                                GainW'($urandom()), GainW'($urandom()));
                4: program_regs('0, '0, '0, GainW'($urandom_range(0, GainMax)),
                                GainW'($urandom_range(1, 2000)));
                default: program_regs(GainW'($urandom_range(0, GainMax)),
                                      GainW'($urandom_range(0, GainMax)),
                                      GainW'($urandom_range(0, GainMax)),
                                      GainW'($urandom_range(0, GainMax)),
                                      MaxDtRst);
            endcase
            quiet = (phase == 2);
            for (n = 0; n < PhaseItems; n++)
            begin
                // long output hold-off so the block backs up into its input
                if (phase == 1 && n == 100)
                begin
                    hold_req = 1'b1;
                end
                random_item();
            end
        end
        quiet = 1'b0;

        drain();
        repeat (TailCycles) @(posedge clk);
        $display("covered %0d predict, %0d altitude, %0d acceleration and %0d combined items",
                 sent_by_kind[ACT_PREDICT], sent_by_kind[ACT_ALT], sent_by_kind[ACT_ACC],
                 sent_by_kind[ACT_BOTH]);
        $display("under %0d register settings, including zero and largest gains and clamps",
                 settings);
        if (mismatches == 0 && pending == 0)
        begin
            $display("fixed_gain_altitude_estimator_top test passed");
        end
        else
        begin
            $display("fixed_gain_altitude_estimator_top test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/fgae_pkg.sv
design/fgae_ctrl.sv
design/fgae_dp.sv
design/fixed_gain_altitude_estimator_top.sv
verif/fgae_checker.sv
verif/testbench.sv
